@@ hw/rtl/nmt_pkg.sv @@
`default_nettype none

package nmt_pkg;

    localparam int TABLE_DEPTH_DEF = 32;

    localparam int IP_W   = 32;
    localparam int PORT_W = 16;
    localparam int AGE_W  = 16;

    localparam logic [PORT_W-1:0] MIN_PORT_RST = 16'd1024;
    localparam logic [PORT_W-1:0] MAX_PORT_RST = 16'd65535;

    localparam logic [1:0] OP_LOOKUP_INT = 2'd0;
    localparam logic [1:0] OP_LOOKUP_EXT = 2'd1;
    localparam logic [1:0] OP_INSERT     = 2'd2;
    localparam logic [1:0] OP_REMOVE     = 2'd3;

    localparam logic [1:0] ST_HIT  = 2'd0;
    localparam logic [1:0] ST_NEW  = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic CFG_MIN_PORT = 1'b0;
    localparam logic CFG_MAX_PORT = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              kind;
        logic [IP_W-1:0]   in_addr;
        logic [PORT_W-1:0] in_port;
        logic [PORT_W-1:0] ex_port;
        logic [AGE_W-1:0]  stamp;
    } t_entry;

endpackage

`default_nettype wire

@@ hw/rtl/nat_mapping_table.sv @@
// operation: an accepted word is compared with every entry of the memory, read through its
//   single read port, one entry per cycle, and the result is then registered in the final
//   state; no new word is taken until that result leaves the final state, and a result
//   held by the receiver holds the next word in the final state
// reset: synchronous, active low; afterwards a clearing pass invalidates every entry in
//   turn, and no word is taken until it ends
`default_nettype none

module nat_mapping_table #(
    parameter int TABLE_DEPTH = nmt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_wdata,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic        i_map_type,
    input  wire logic [31:0] i_internal_ip,
    input  wire logic [15:0] i_internal_port,
    input  wire logic [15:0] i_external_port,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic             o_out_type,
    output logic [31:0]      o_out_internal_ip,
    output logic [15:0]      o_out_internal_port,
    output logic [15:0]      o_out_external_port
);
    import nmt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]        r_state;
    logic [CW-1:0]     r_cnt;
    logic              r_eval;
    logic [AW-1:0]     r_eval_idx;

    logic [PORT_W-1:0] r_min;
    logic [PORT_W-1:0] r_max;
    logic [AGE_W-1:0]  r_ins_cnt;
    logic [PORT_W-1:0] r_tcp_next;
    logic [PORT_W-1:0] r_icmp_next;

    logic [1:0]        r_op;
    logic              r_kind;
    logic [IP_W-1:0]   r_ip;
    logic [PORT_W-1:0] r_iport;
    logic [PORT_W-1:0] r_eport;

    logic              r_found;
    logic [AW-1:0]     r_best_idx;
    logic [AGE_W-1:0]  r_best_age;
    t_entry            r_best;
    logic              r_free_found;
    logic [AW-1:0]     r_free_idx;

    logic              r_out_valid;
    logic [1:0]        r_status;
    logic              r_out_type;
    logic [IP_W-1:0]   r_out_ip;
    logic [PORT_W-1:0] r_out_iport;
    logic [PORT_W-1:0] r_out_eport;

    t_entry            r_mem [TABLE_DEPTH];
    t_entry            r_rd_data;

    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    t_entry            mem_wd;
    logic [AW-1:0]     mem_ra;

    logic              in_acc;
    logic              out_free;
    logic              key_match;
    logic [AGE_W-1:0]  age;
    logic              take_best;
    logic [PORT_W-1:0] port_sel;
    logic [PORT_W:0]   port_inc;
    logic [PORT_W-1:0] port_next;
    logic              fin_go;
    logic              do_insert;
    logic              do_remove;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign fin_go   = (r_state == S_FIN) && out_free;
    assign mem_ra   = r_cnt[AW-1:0];

    // entry compare on the registered read word
    always_comb begin
        if (r_op == OP_LOOKUP_INT || r_op == OP_INSERT) begin
            key_match = r_rd_data.valid && (r_rd_data.kind == r_kind) &&
                        (r_rd_data.in_addr == r_ip) && (r_rd_data.in_port == r_iport);
        end else begin
            key_match = r_rd_data.valid && (r_rd_data.kind == r_kind) &&
                        (r_rd_data.ex_port == r_eport);
        end
        age       = r_ins_cnt - r_rd_data.stamp;
        take_best = r_eval && key_match && (!r_found || (age < r_best_age));
    end

    // port allocation with wrap
    always_comb begin
        port_sel  = r_kind ? r_tcp_next : r_icmp_next;
        port_inc  = {1'b0, port_sel} + {{PORT_W{1'b0}}, 1'b1};
        port_next = (port_inc > {1'b0, r_max}) ? r_min : port_inc[PORT_W-1:0];
    end

    assign do_insert = fin_go && (r_op == OP_INSERT) && !r_found && r_free_found;
    assign do_remove = fin_go && (r_op == OP_REMOVE) && r_found;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_cnt[AW-1:0];
        mem_wd = '0;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (do_insert) begin
            mem_we         = 1'b1;
            mem_wa         = r_free_idx;
            mem_wd.valid   = 1'b1;
            mem_wd.kind    = r_kind;
            mem_wd.in_addr = r_ip;
            mem_wd.in_port = r_iport;
            mem_wd.ex_port = port_sel;
            mem_wd.stamp   = r_ins_cnt;
        end else if (do_remove) begin
            mem_we       = 1'b1;
            mem_wa       = r_best_idx;
            mem_wd       = r_best;
            mem_wd.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_eval      <= 1'b0;
            r_min       <= MIN_PORT_RST;
            r_max       <= MAX_PORT_RST;
            r_ins_cnt   <= '0;
            r_tcp_next  <= MIN_PORT_RST;
            r_icmp_next <= MIN_PORT_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_MIN_PORT) begin
                    r_min <= i_cfg_wdata;
                end else begin
                    r_max <= i_cfg_wdata;
                end
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_eval <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    if (r_cnt == CW'(TABLE_DEPTH - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_cnt   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_cnt == CW'(TABLE_DEPTH)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_eval <= 1'b1;
                        r_cnt  <= r_cnt + 1'b1;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_cnt       <= '0;
                        r_state     <= S_IDLE;
                        if (do_insert) begin
                            r_ins_cnt <= r_ins_cnt + 1'b1;
                            if (r_kind) begin
                                r_tcp_next <= port_next;
                            end else begin
                                r_icmp_next <= port_next;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // scan bookkeeping and result payload
    always_ff @(posedge i_clk) begin
        r_eval_idx <= mem_ra;
        if (in_acc) begin
            r_op         <= i_opcode;
            r_kind       <= i_map_type;
            r_ip         <= i_internal_ip;
            r_iport      <= i_internal_port;
            r_eport      <= i_external_port;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            if (take_best) begin
                r_found    <= 1'b1;
                r_best_idx <= r_eval_idx;
                r_best_age <= age;
                r_best     <= r_rd_data;
            end
            if (r_eval && !r_rd_data.valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_eval_idx;
            end
        end
        if (fin_go) begin
            if (r_found) begin
                r_status    <= (r_op == OP_REMOVE) ? ST_NEW : ST_HIT;
                r_out_type  <= r_best.kind;
                r_out_ip    <= r_best.in_addr;
                r_out_iport <= r_best.in_port;
                r_out_eport <= r_best.ex_port;
            end else if (do_insert) begin
                r_status    <= ST_NEW;
                r_out_type  <= r_kind;
                r_out_ip    <= r_ip;
                r_out_iport <= r_iport;
                r_out_eport <= port_sel;
            end else begin
                r_status    <= (r_op == OP_INSERT) ? ST_FULL : ST_MISS;
                r_out_type  <= 1'b0;
                r_out_ip    <= '0;
                r_out_iport <= '0;
                r_out_eport <= '0;
            end
        end
    end

    assign o_in_ready          = (r_state == S_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_status            = r_status;
    assign o_out_type          = r_out_type;
    assign o_out_internal_ip   = r_out_ip;
    assign o_out_internal_port = r_out_iport;
    assign o_out_external_port = r_out_eport;

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import nmt_pkg::*;

    localparam int DEPTH       = TABLE_DEPTH_DEF;
    localparam int PHASE_WORDS = 220;
    localparam int NUM_PHASES  = 8;
    localparam int HOLD_CYCLES = 500;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        kind;
        logic [31:0] ip;
        logic [15:0] iport;
        logic [15:0] eport;
    } nat_request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        kind;
        logic [31:0] ip;
        logic [15:0] iport;
        logic [15:0] eport;
    } nat_answer_t;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_wr_en     = 1'b0;
    logic        i_cfg_index     = 1'b0;
    logic [15:0] i_cfg_wdata     = '0;
    logic        i_in_valid      = 1'b0;
    logic [1:0]  i_opcode        = '0;
    logic        i_map_type      = 1'b0;
    logic [31:0] i_internal_ip   = '0;
    logic [15:0] i_internal_port = '0;
    logic [15:0] i_external_port = '0;
    logic        i_out_ready     = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic        o_out_type;
    logic [31:0] o_out_internal_ip;
    logic [15:0] o_out_internal_port;
    logic [15:0] o_out_external_port;

    nat_mapping_table #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_opcode            (i_opcode),
        .i_map_type          (i_map_type),
        .i_internal_ip       (i_internal_ip),
        .i_internal_port     (i_internal_port),
        .i_external_port     (i_external_port),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_out_type          (o_out_type),
        .o_out_internal_ip   (o_out_internal_ip),
        .o_out_internal_port (o_out_internal_port),
        .o_out_external_port (o_out_external_port)
    );

    always #2 i_clk = ~i_clk;

    // shadow of the translation table
    logic        slot_live  [DEPTH];
    logic        slot_kind  [DEPTH];
    logic [31:0] slot_ip    [DEPTH];
    logic [15:0] slot_iport [DEPTH];
    logic [15:0] slot_eport [DEPTH];
    logic [15:0] slot_stamp [DEPTH];
    logic [15:0] insert_seq;
    logic [15:0] tcp_port_next;
    logic [15:0] icmp_port_next;
    logic [15:0] cfg_min;
    logic [15:0] cfg_max;

    logic [31:0] ip_pool    [6];
    logic [15:0] iport_pool [6];

    nat_request_t requests_pending [$];
    nat_answer_t  answers_due [$];
    nat_request_t req_now;
    int           gap_left;
    int           stall_left;
    int           answers_seen;
    int           mismatches = 0;
    bit           no_idle    = 1'b0;

    logic [15:0] phase_min [NUM_PHASES] = '{16'd0, 16'd100, 16'd65533, 16'd200,
                                            16'd0, 16'd65535, 16'd1024, 16'd1024};
    logic [15:0] phase_max [NUM_PHASES] = '{16'd65535, 16'd103, 16'd65535, 16'd150,
                                            16'd0, 16'd65535, 16'd1100, 16'd65535};

    function automatic int idle_len();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    function automatic int newest_inside(logic k, logic [31:0] ip, logic [15:0] p);
        int          best;
        logic [15:0] best_age;
        logic [15:0] age;
        best     = -1;
        best_age = '0;
        for (int i = 0; i < DEPTH; i++) begin
            age = insert_seq - slot_stamp[i];
            if (slot_live[i] && slot_kind[i] == k && slot_ip[i] == ip &&
                slot_iport[i] == p && (best < 0 || age < best_age)) begin
                best     = i;
                best_age = age;
            end
        end
        return best;
    endfunction

    function automatic int newest_outside(logic k, logic [15:0] p);
        int          best;
        logic [15:0] best_age;
        logic [15:0] age;
        best     = -1;
        best_age = '0;
        for (int i = 0; i < DEPTH; i++) begin
            age = insert_seq - slot_stamp[i];
            if (slot_live[i] && slot_kind[i] == k && slot_eport[i] == p &&
                (best < 0 || age < best_age)) begin
                best     = i;
                best_age = age;
            end
        end
        return best;
    endfunction

    // next counter value, wrap compared at 17 bits
    function automatic logic [15:0] advance_port(logic [15:0] p);
        logic [16:0] bump;
        bump = {1'b0, p} + 17'd1;
        return (bump > {1'b0, cfg_max}) ? cfg_min : bump[15:0];
    endfunction

    task automatic translate_word(input nat_request_t r);
        int          s;
        nat_answer_t a;
        s = -1;
        a = '0;
        case (r.opcode)
            OP_LOOKUP_INT: begin
                s = newest_inside(r.kind, r.ip, r.iport);
                a.status = (s < 0) ? ST_MISS : ST_HIT;
            end
            OP_LOOKUP_EXT: begin
                s = newest_outside(r.kind, r.eport);
                a.status = (s < 0) ? ST_MISS : ST_HIT;
            end
            OP_INSERT: begin
                s = newest_inside(r.kind, r.ip, r.iport);
                if (s >= 0) begin
                    a.status = ST_HIT;
                end else begin
                    for (int i = 0; i < DEPTH && s < 0; i++)
                        if (!slot_live[i]) s = i;
                    if (s < 0) begin
                        a.status = ST_FULL;
                    end else begin
                        slot_live[s]  = 1'b1;
                        slot_kind[s]  = r.kind;
                        slot_ip[s]    = r.ip;
                        slot_iport[s] = r.iport;
                        if (r.kind) begin
                            slot_eport[s] = tcp_port_next;
                            tcp_port_next = advance_port(tcp_port_next);
                        end else begin
                            slot_eport[s]  = icmp_port_next;
                            icmp_port_next = advance_port(icmp_port_next);
                        end
                        slot_stamp[s] = insert_seq;
                        insert_seq    = insert_seq + 16'd1;
                        a.status      = ST_NEW;
                    end
                end
            end
            default: begin
                s = newest_outside(r.kind, r.eport);
                a.status = (s < 0) ? ST_MISS : ST_NEW;
            end
        endcase
        if (s >= 0) begin
            a.kind  = slot_kind[s];
            a.ip    = slot_ip[s];
            a.iport = slot_iport[s];
            a.eport = slot_eport[s];
            if (r.opcode == OP_REMOVE) slot_live[s] = 1'b0;
        end
        answers_due.push_back(a);
    endtask

    function automatic int live_count();
        int cnt;
        cnt = 0;
        foreach (slot_live[i]) cnt += int'(slot_live[i]);
        return cnt;
    endfunction

    function automatic int pick_live();
        int k;
        k = live_count();
        if (k == 0) return -1;
        k = $urandom_range(0, k - 1);
        foreach (slot_live[i]) begin
            if (slot_live[i]) begin
                if (k == 0) return i;
                k--;
            end
        end
        return -1;
    endfunction

    // mostly words aimed at live mappings, some noise
    task automatic make_request(output nat_request_t r);
        int live;
        int roll;
        int s;
        live     = live_count();
        r.opcode = OP_LOOKUP_INT;
        r.kind   = 1'($urandom_range(0, 1));
        r.ip     = $urandom;
        r.iport  = 16'($urandom);
        r.eport  = 16'($urandom);
        if ($urandom_range(0, 99) < 5) begin
            r.opcode = 2'($urandom_range(0, 3));
            return;
        end
        roll = $urandom_range(0, 99);
        if (roll < ((live >= DEPTH - 2) ? 25 : (live < 3) ? 60 : 40)) begin
            r.opcode = OP_INSERT;
        end else begin
            roll = $urandom_range(0, 9);
            r.opcode = (roll < 3) ? OP_LOOKUP_INT : (roll < 6) ? OP_LOOKUP_EXT : OP_REMOVE;
        end
        s = pick_live();
        case (r.opcode)
            OP_INSERT, OP_LOOKUP_INT: begin
                if (s >= 0 && $urandom_range(0, 3) != 0 &&
                    (r.opcode == OP_LOOKUP_INT || $urandom_range(0, 2) == 0)) begin
                    r.kind  = slot_kind[s] ^ ($urandom_range(0, 9) == 0);
                    r.ip    = slot_ip[s];
                    r.iport = slot_iport[s];
                end else begin
                    if ($urandom_range(0, 9) != 0) r.ip = ip_pool[$urandom_range(0, 5)];
                    if ($urandom_range(0, 9) != 0) r.iport = iport_pool[$urandom_range(0, 5)];
                end
            end
            default: begin
                if (s >= 0 && $urandom_range(0, 4) != 0) begin
                    r.kind  = slot_kind[s];
                    r.eport = slot_eport[s];
                end else if ($urandom_range(0, 1) == 0) begin
                    r.eport = cfg_min + 16'($urandom_range(0, 8));
                end
            end
        endcase
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_MIN_PORT) cfg_min = val;
        else cfg_max = val;
    endtask

    task automatic wait_drained();
        while (requests_pending.size() != 0 || i_in_valid || answers_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic queue_word(input logic [1:0] op, input logic k, input logic [31:0] ip,
                              input logic [15:0] iport, input logic [15:0] eport);
        nat_request_t r;
        r = '{op, k, ip, iport, eport};
        requests_pending.push_back(r);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : driver
        nat_request_t nxt;
        bit           stuck;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
        end else begin
            if (i_in_valid && o_in_ready) translate_word(req_now);
            stuck = i_in_valid && !o_in_ready;
            if (!stuck) begin
                if (gap_left > 0) begin
                    i_in_valid <= 1'b0;
                    gap_left   <= gap_left - 1;
                end else if (requests_pending.size() != 0) begin
                    nxt = requests_pending.pop_front();
                    req_now         <= nxt;
                    i_opcode        <= nxt.opcode;
                    i_map_type      <= nxt.kind;
                    i_internal_ip   <= nxt.ip;
                    i_internal_port <= nxt.iport;
                    i_external_port <= nxt.eport;
                    i_in_valid      <= 1'b1;
                    gap_left        <= idle_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        nat_answer_t want;
        bit          took;
        int          n;
        if (!i_rst_n) begin
            i_out_ready  <= 1'b0;
            stall_left   <= 0;
            answers_seen <= 0;
        end else begin
            took = o_out_valid && i_out_ready;
            if (took) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual status %0h",
                             $time, o_status);
                    mismatches++;
                end else begin
                    want = answers_due.pop_front();
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("out_type", 32'(want.kind), 32'(o_out_type));
                    check_field("out_internal_ip", want.ip, o_out_internal_ip);
                    check_field("out_internal_port", 32'(want.iport),
                                32'(o_out_internal_port));
                    check_field("out_external_port", 32'(want.eport),
                                32'(o_out_external_port));
                end
                answers_seen <= answers_seen + 1;
            end
            // long hold so the table backs up into the input
            if (took && answers_seen % 250 == 120) begin
                i_out_ready <= 1'b0;
                stall_left  <= HOLD_CYCLES;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left  <= stall_left - 1;
            end else begin
                n = idle_len();
                i_out_ready <= (n == 0);
                stall_left  <= (n == 0) ? 0 : n - 1;
            end
        end
    end

    initial begin : stimulus
        nat_request_t r;
        foreach (slot_live[i]) begin
            slot_live[i]  = 1'b0;
            slot_kind[i]  = 1'b0;
            slot_ip[i]    = '0;
            slot_iport[i] = '0;
            slot_eport[i] = '0;
            slot_stamp[i] = '0;
        end
        insert_seq     = '0;
        cfg_min        = MIN_PORT_RST;
        cfg_max        = MAX_PORT_RST;
        tcp_port_next  = MIN_PORT_RST;
        icmp_port_next = MIN_PORT_RST;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed words at the reset settings
        queue_word(OP_LOOKUP_INT, 1'b0, 32'h0, 16'h0, 16'h0);
        queue_word(OP_LOOKUP_EXT, 1'b1, 32'hffff_ffff, 16'hffff, 16'hffff);
        queue_word(OP_REMOVE, 1'b0, 32'h0, 16'h0, 16'h0);
        queue_word(OP_INSERT, 1'b0, 32'h0, 16'h0, 16'hffff);
        queue_word(OP_INSERT, 1'b1, 32'hffff_ffff, 16'hffff, 16'h0);
        queue_word(OP_INSERT, 1'b0, 32'h0, 16'h0, 16'h0);
        queue_word(OP_INSERT, 1'b1, 32'h0, 16'h0, 16'h0);
        queue_word(OP_LOOKUP_INT, 1'b1, 32'hffff_ffff, 16'hffff, 16'h0);
        queue_word(OP_LOOKUP_INT, 1'b0, 32'hffff_ffff, 16'hffff, 16'h0);
        queue_word(OP_LOOKUP_EXT, 1'b0, 32'h0, 16'h0, 16'd1024);
        queue_word(OP_LOOKUP_EXT, 1'b1, 32'h0, 16'h0, 16'd1025);
        queue_word(OP_LOOKUP_EXT, 1'b0, 32'h0, 16'h0, 16'd1025);
        queue_word(OP_REMOVE, 1'b0, 32'h0, 16'h0, 16'd1024);
        queue_word(OP_REMOVE, 1'b0, 32'h0, 16'h0, 16'd1024);
        queue_word(OP_INSERT, 1'b0, 32'h1234_5678, 16'd80, 16'h0);
        queue_word(OP_LOOKUP_EXT, 1'b1, 32'h0, 16'h0, 16'h0);
        queue_word(OP_LOOKUP_INT, 1'b0, 32'h1234_5678, 16'd80, 16'hffff);
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_reg(CFG_MIN_PORT, phase_min[ph]);
            write_reg(CFG_MAX_PORT, phase_max[ph]);
            no_idle       = (ph == 1);
            ip_pool[0]    = 32'h0;
            ip_pool[1]    = 32'hffff_ffff;
            iport_pool[0] = 16'h0;
            iport_pool[1] = 16'hffff;
            for (int i = 2; i < 6; i++) begin
                ip_pool[i]    = $urandom;
                iport_pool[i] = 16'($urandom);
            end
            @(negedge i_clk);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                while (requests_pending.size() >= 2) @(negedge i_clk);
                make_request(r);
                requests_pending.push_back(r);
            end
            wait_drained();
        end

        repeat (DEPTH + 12) @(posedge i_clk);
        if (mismatches == 0 && answers_due.size() == 0)
            $display("nat_mapping_table verification clean");
        else
            $display("nat_mapping_table verification failed");
        $finish;
    end

    initial begin : watchdog
        #8000000;
        $display("nat_mapping_table verification failed");
        $finish;
    end

endmodule
